/* rtl/bpra_pkg.sv */
// Shared types and constants for the bitmap page run allocator.
// Depends on nothing; every rtl file refers to it by scoped names.
`timescale 1ns / 1ps

package bpra_pkg;

  localparam int MAX_PAGES   = 1024;
  localparam int PAGE_W      = $clog2(MAX_PAGES);       // page index width
  localparam int CNT_W       = PAGE_W + 1;              // counts up to MAX_PAGES
  localparam int WORD_W      = 32;                      // bitmap word width
  localparam int WORD_BITS_W = $clog2(WORD_W);
  localparam int NUM_WORDS   = MAX_PAGES / WORD_W;
  localparam int WADDR_W     = $clog2(NUM_WORDS);
  localparam int SCAN_W      = 8;                       // pages examined per scan cycle
  localparam int SCAN_SH     = $clog2(SCAN_W);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADFREE = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_CHECK,
    S_CLEAR,
    S_REPLY
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [CNT_W-1:0]  run_length;
    logic [PAGE_W-1:0] start_index;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [PAGE_W-1:0] found_index;
  } rsp_t;

  // Word access into the bitmap: range lo..hi masked inside word addr.
  typedef struct packed {
    logic               wr_en;
    logic               set_bits;
    logic [WADDR_W-1:0] addr;
    logic [PAGE_W-1:0]  lo;
    logic [PAGE_W-1:0]  hi;
  } map_cmd_t;

endpackage

/* rtl/bpra_map.sv */
// Used-page bitmap, held as words, with the shared range-mask unit.
// Depends on bpra_pkg.
`timescale 1ns / 1ps

module bpra_map (
  input  logic                           clk,
  input  logic                           rst,
  input  bpra_pkg::map_cmd_t             cmd,
  output logic [bpra_pkg::WORD_W-1:0]    rd_word,
  output logic                           hit
);

  logic [bpra_pkg::WORD_W-1:0] words [bpra_pkg::NUM_WORDS];
  logic [bpra_pkg::WORD_W-1:0] mask;
  logic [bpra_pkg::PAGE_W-1:0] idx;

  assign rd_word = words[cmd.addr];

  // mask bit set for every page of this word inside lo..hi
  always_comb begin
    mask = '0;
    idx  = '0;
    for (int b = 0; b < bpra_pkg::WORD_W; b++) begin
      idx     = {cmd.addr, bpra_pkg::WORD_BITS_W'(b)};
      mask[b] = (idx >= cmd.lo) && (idx <= cmd.hi);
    end
  end

  // all masked pages in use
  assign hit = (rd_word & mask) == mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < bpra_pkg::NUM_WORDS; w++) begin
        words[w] <= '0;
      end
    end else if (cmd.wr_en) begin
      if (cmd.set_bits) begin
        words[cmd.addr] <= rd_word | mask;
      end else begin
        words[cmd.addr] <= rd_word & ~mask;
      end
    end
  end

endmodule

/* rtl/bpra_ctrl.sv */
// Sequencer: first-fit scan, run marking, free check and clear.
// Depends on bpra_pkg; drives bpra_map through a map_cmd_t.
`timescale 1ns / 1ps

module bpra_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  bpra_pkg::req_t                 req,
  input  logic [bpra_pkg::CNT_W-1:0]     limit,
  input  logic [bpra_pkg::WORD_W-1:0]    rd_word,
  input  logic                           hit,
  output logic                           busy,
  output logic                           done,
  output bpra_pkg::rsp_t                 rsp,
  output bpra_pkg::map_cmd_t             map_cmd
);

  localparam int PW = bpra_pkg::PAGE_W;
  localparam int CW = bpra_pkg::CNT_W;
  localparam int WB = bpra_pkg::WORD_BITS_W;

  bpra_pkg::state_t  state, state_next;
  bpra_pkg::op_t     op_q, op_next;
  bpra_pkg::status_t status_q, status_next;
  logic [PW-1:0] found_q, found_next;
  logic [CW-1:0] len_q, len_next;
  logic [PW-1:0] first_q, first_next;
  logic [PW-1:0] last_q, last_next;
  logic [CW-1:0] pos_q, pos_next;
  logic [CW-1:0] run_q, run_next;
  logic [CW-1:0] rs_q, rs_next;
  logic [bpra_pkg::WADDR_W-1:0] waddr_q, waddr_next;

  // request decode
  logic          alloc_reject;
  logic          free_empty;
  logic          free_over;
  logic [CW:0]   free_end;
  logic [PW-1:0] free_last;

  // scan step
  logic [bpra_pkg::SCAN_W-1:0] slice;
  logic [CW-1:0] p;
  logic [CW-1:0] run_v;
  logic [CW-1:0] rs_v;
  logic          found_v;
  logic [PW-1:0] last_v;
  logic          scan_end;
  logic          last_word;

  always_comb begin
    free_end     = {1'b0, CW'(req.start_index)} + {1'b0, req.run_length};
    free_last    = PW'(free_end - (CW+1)'(1));
    alloc_reject = (req.run_length == '0) || (req.run_length > limit);
    free_empty   = req.run_length == '0;
    free_over    = free_end > {1'b0, limit};
  end

  // examine SCAN_W pages starting at pos_q
  always_comb begin
    slice   = rd_word[pos_q[WB-1:bpra_pkg::SCAN_SH]*bpra_pkg::SCAN_W +: bpra_pkg::SCAN_W];
    run_v   = run_q;
    rs_v    = rs_q;
    found_v = 1'b0;
    last_v  = '0;
    p       = '0;
    for (int j = 0; j < bpra_pkg::SCAN_W; j++) begin
      p = pos_q + CW'(j);
      if (!found_v && (p < limit)) begin
        if (slice[j]) begin
          run_v = '0;
          rs_v  = p + CW'(1);
        end else begin
          run_v = run_v + CW'(1);
        end
        if (run_v == len_q) begin
          found_v = 1'b1;
          last_v  = p[PW-1:0];
        end
      end
    end
  end

  assign scan_end  = (pos_q + CW'(bpra_pkg::SCAN_W)) >= limit;
  assign last_word = waddr_q == last_q[PW-1:WB];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bpra_pkg::S_IDLE: begin
        if (start) begin
          if (req.op == bpra_pkg::OP_ALLOC) begin
            state_next = alloc_reject ? bpra_pkg::S_REPLY : bpra_pkg::S_SCAN;
          end else if (free_empty || free_over) begin
            state_next = bpra_pkg::S_REPLY;
          end else begin
            state_next = bpra_pkg::S_CHECK;
          end
        end
      end
      bpra_pkg::S_SCAN: begin
        if (found_v) begin
          state_next = bpra_pkg::S_MARK;
        end else if (scan_end) begin
          state_next = bpra_pkg::S_REPLY;
        end
      end
      bpra_pkg::S_MARK: begin
        if (last_word) state_next = bpra_pkg::S_REPLY;
      end
      bpra_pkg::S_CHECK: begin
        if (!hit) begin
          state_next = bpra_pkg::S_REPLY;
        end else if (last_word) begin
          state_next = bpra_pkg::S_CLEAR;
        end
      end
      bpra_pkg::S_CLEAR: begin
        if (last_word) state_next = bpra_pkg::S_REPLY;
      end
      bpra_pkg::S_REPLY: state_next = bpra_pkg::S_IDLE;
      default:           state_next = bpra_pkg::S_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    op_next     = op_q;
    status_next = status_q;
    found_next  = found_q;
    len_next    = len_q;
    first_next  = first_q;
    last_next   = last_q;
    pos_next    = pos_q;
    run_next    = run_q;
    rs_next     = rs_q;
    waddr_next  = waddr_q;
    unique case (state)
      bpra_pkg::S_IDLE: begin
        if (start) begin
          op_next    = req.op;
          len_next   = req.run_length;
          found_next = '0;
          pos_next   = '0;
          run_next   = '0;
          rs_next    = '0;
          if (req.op == bpra_pkg::OP_ALLOC) begin
            status_next = bpra_pkg::ST_NOFIT;
          end else if (free_empty) begin
            status_next = bpra_pkg::ST_EMPTY;
          end else if (free_over) begin
            status_next = bpra_pkg::ST_BADFREE;
          end else begin
            first_next = req.start_index;
            last_next  = free_last;
            waddr_next = req.start_index[PW-1:WB];
          end
        end
      end
      bpra_pkg::S_SCAN: begin
        if (found_v) begin
          first_next = rs_v[PW-1:0];
          last_next  = last_v;
          waddr_next = rs_v[PW-1:WB];
        end else if (scan_end) begin
          status_next = bpra_pkg::ST_NOFIT;
        end else begin
          pos_next = pos_q + CW'(bpra_pkg::SCAN_W);
          run_next = run_v;
          rs_next  = rs_v;
        end
      end
      bpra_pkg::S_MARK: begin
        if (last_word) begin
          status_next = bpra_pkg::ST_DONE;
          found_next  = first_q;
        end else begin
          waddr_next = waddr_q + 1'b1;
        end
      end
      bpra_pkg::S_CHECK: begin
        if (!hit) begin
          status_next = bpra_pkg::ST_BADFREE;
        end else if (last_word) begin
          waddr_next = first_q[PW-1:WB];
        end else begin
          waddr_next = waddr_q + 1'b1;
        end
      end
      bpra_pkg::S_CLEAR: begin
        if (last_word) begin
          status_next = bpra_pkg::ST_DONE;
        end else begin
          waddr_next = waddr_q + 1'b1;
        end
      end
      bpra_pkg::S_REPLY: begin
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    busy             = 1'b1;
    done             = 1'b0;
    map_cmd.wr_en    = 1'b0;
    map_cmd.set_bits = 1'b0;
    map_cmd.addr     = waddr_q;
    map_cmd.lo       = first_q;
    map_cmd.hi       = last_q;
    unique case (state)
      bpra_pkg::S_IDLE:  busy = 1'b0;
      bpra_pkg::S_SCAN:  map_cmd.addr = pos_q[PW-1:WB];
      bpra_pkg::S_MARK: begin
        map_cmd.wr_en    = 1'b1;
        map_cmd.set_bits = 1'b1;
      end
      bpra_pkg::S_CHECK: begin
      end
      bpra_pkg::S_CLEAR: map_cmd.wr_en = 1'b1;
      bpra_pkg::S_REPLY: done = 1'b1;
      default:           busy = 1'b0;
    endcase
  end

  assign rsp.status      = status_q;
  assign rsp.found_index = found_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpra_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q     <= op_next;
    status_q <= status_next;
    found_q  <= found_next;
    len_q    <= len_next;
    first_q  <= first_next;
    last_q   <= last_next;
    pos_q    <= pos_next;
    run_q    <= run_next;
    rs_q     <= rs_next;
    waddr_q  <= waddr_next;
  end

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not start work");

  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status != bpra_pkg::ST_DONE)) |-> (rsp.found_index == '0))
    else $error("found index nonzero on failed request");

  a_free_found: assert property (@(posedge clk) disable iff (rst)
    (done && (op_q == bpra_pkg::OP_FREE)) |-> (rsp.found_index == '0))
    else $error("free reported a found index");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == bpra_pkg::S_SCAN) |-> (pos_q < limit))
    else $error("scan ran past pool limit");
`endif

endmodule

/* rtl/bitmap_page_run_allocator_unit.sv */
// Top level of the bitmap page run allocator: pool size register,
// sequencer and bitmap. Depends on bpra_pkg, bpra_ctrl and bpra_map.
`timescale 1ns / 1ps

// Page run allocator over a 1024-page used bitmap, cleared by reset.
// A request is transferred on a clock edge with start high and busy low;
// busy then stays high until the single result has gone out. The result
// is valid on rsp for exactly one cycle, marked by done, and cannot be
// held off by the receiver. Allocate scans the bitmap first-fit, eight
// pages per cycle through one shared scan step, then sets the run one
// 32-bit word per cycle. A rejected request (zero length, or longer
// than the pool) goes straight to the reply. Free checks every word of
// the run, then clears it, one word per cycle each pass; an empty or
// out-of-pool free goes straight to the reply. The next request can be
// taken the cycle after done. pool_pages is written with cfg_we/cfg_data
// and must only change while busy is low; values above 1024 act as 1024.
// Shrinking the pool keeps bits above the new size set.
module bitmap_page_run_allocator_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  bpra_pkg::req_t               req,
  output logic                         busy,
  output logic                         done,
  output bpra_pkg::rsp_t               rsp,
  input  logic                         cfg_we,
  input  logic [bpra_pkg::CNT_W-1:0]   cfg_data
);

  localparam int CW = bpra_pkg::CNT_W;

  logic [CW-1:0]                 pool_pages;
  logic [CW-1:0]                 limit;
  logic [bpra_pkg::WORD_W-1:0]   rd_word;
  logic                          hit;
  bpra_pkg::map_cmd_t            map_cmd;

  // pool size register; resets to the full pool
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_pages <= CW'(bpra_pkg::MAX_PAGES);
    end else if (cfg_we) begin
      pool_pages <= cfg_data;
    end
  end

  // usable pages: pool size clamped to the bitmap depth
  assign limit = (pool_pages > CW'(bpra_pkg::MAX_PAGES)) ?
                 CW'(bpra_pkg::MAX_PAGES) : pool_pages;

  bpra_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req     (req),
    .limit   (limit),
    .rd_word (rd_word),
    .hit     (hit),
    .busy    (busy),
    .done    (done),
    .rsp     (rsp),
    .map_cmd (map_cmd)
  );

  bpra_map u_map (
    .clk     (clk),
    .rst     (rst),
    .cmd     (map_cmd),
    .rd_word (rd_word),
    .hit     (hit)
  );

endmodule

/* sim/tb_bitmap_page_run_allocator_unit.sv */
// Self-checking testbench for bitmap_page_run_allocator_unit: first-fit page
// run allocation and run release against an in-bench bitmap predictor.
// Depends on bpra_pkg and the unit itself; standalone, no files or arguments.
`timescale 1ns / 1ps

module tb_bitmap_page_run_allocator_unit;

  // Watchdog limit in cycles with no transfer at all. It stays many times
  // above the longest legal quiet spell: the slowest request (full-pool
  // scan plus marking) or the longest driver gap.
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int DRAIN_CYCLES = 24;

  // One backlog entry: either a request or a pool size write.
  typedef struct packed {
    logic                       is_cfg;
    logic [bpra_pkg::CNT_W-1:0] pool_value;
    bpra_pkg::req_t             item;
  } backlog_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  bpra_pkg::req_t             req = '0;
  logic                       busy;
  logic                       done;
  bpra_pkg::rsp_t             rsp;
  logic                       cfg_we = 1'b0;
  logic [bpra_pkg::CNT_W-1:0] cfg_data = '0;

  bitmap_page_run_allocator_unit dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .busy     (busy),
    .done     (done),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Predictor state: our own copy of the used-page map and the pool size.
  logic [bpra_pkg::MAX_PAGES-1:0] page_map = '0;
  logic [bpra_pkg::CNT_W-1:0]     pool_shadow = bpra_pkg::CNT_W'(bpra_pkg::MAX_PAGES);

  backlog_t       request_backlog[$];   // filled by the stimulus block
  bpra_pkg::rsp_t expected_replies[$];  // oldest first, one per accepted request
  bpra_pkg::op_t  expected_ops[$];      // op of each pending reply, for the summary

  int mismatches = 0;
  int stall_cycles = 0;
  int gap_left = 0;
  bit steady_mode = 0;            // stretch with no driver idling
  int n_placed = 0, n_nofit = 0, n_released = 0, n_badfree = 0, n_empty = 0;
  int n_pool_writes = 0;

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor: applies one accepted request to the shadow bitmap and
  // returns the reply the unit has to give for it.
  // ---------------------------------------------------------------------
  function automatic bpra_pkg::rsp_t apply_page_request(bpra_pkg::req_t r);
    bpra_pkg::rsp_t res;
    int   usable;
    int   len;
    int   first;
    int   run;
    bit   all_used;
    res.status      = bpra_pkg::ST_NOFIT;
    res.found_index = '0;
    usable = (pool_shadow > bpra_pkg::MAX_PAGES) ? bpra_pkg::MAX_PAGES : int'(pool_shadow);
    len    = int'(r.run_length);
    first  = int'(r.start_index);
    if (r.op == bpra_pkg::OP_ALLOC) begin
      // first fit: lowest index where len consecutive free pages end
      if (len != 0) begin
        run = 0;
        for (int i = 0; i < usable; i++) begin
          run = page_map[i] ? 0 : run + 1;
          if (run == len) begin
            for (int k = i + 1 - len; k <= i; k++) page_map[k] = 1'b1;
            res.status      = bpra_pkg::ST_DONE;
            res.found_index = bpra_pkg::PAGE_W'(i + 1 - len);
            break;
          end
        end
      end
    end else begin
      if (len == 0) begin
        res.status = bpra_pkg::ST_EMPTY;
      end else if (first + len > usable) begin
        // also catches pages kept above a shrunk pool
        res.status = bpra_pkg::ST_BADFREE;
      end else begin
        all_used = 1'b1;
        for (int i = first; i < first + len; i++)
          if (!page_map[i]) all_used = 1'b0;
        if (all_used) begin
          for (int i = first; i < first + len; i++) page_map[i] = 1'b0;
          res.status = bpra_pkg::ST_DONE;
        end else begin
          res.status = bpra_pkg::ST_BADFREE;
        end
      end
    end
    return res;
  endfunction

  // Driver gap after each transfer: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) steady_mode = !steady_mode;
    if (steady_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(8, 60);
  endfunction

  // ---------------------------------------------------------------------
  // Driver. A request is transferred at an edge with start high and busy
  // low. start stays high across busy, so a queued request waits on the
  // handshake. Pool writes go out only when the unit is idle and every
  // reply has come back. Each DUT input gets one nonblocking update per
  // edge, computed in blocking locals first.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive
    backlog_t nxt;
    logic     hold;
    logic     we_now;
    if (rst) begin
      start    <= 1'b0;
      req      <= '0;
      cfg_we   <= 1'b0;
      cfg_data <= '0;
      gap_left = 0;
    end else begin
      hold   = start;
      we_now = 1'b0;
      if (start && !busy) begin
        expected_replies.push_back(apply_page_request(req));
        expected_ops.push_back(req.op);
        hold     = 1'b0;
        gap_left = pick_gap();
      end
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_backlog.size() != 0) begin
          if (request_backlog[0].is_cfg) begin
            if (!busy && !cfg_we && expected_replies.size() == 0) begin
              nxt = request_backlog.pop_front();
              we_now      = 1'b1;
              cfg_data    <= nxt.pool_value;
              pool_shadow = nxt.pool_value;
              n_pool_writes++;
            end
          end else begin
            nxt  = request_backlog.pop_front();
            req  <= nxt.item;
            hold = 1'b1;
          end
        end
      end
      start  <= hold;
      cfg_we <= we_now;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every done cycle is one reply transfer; compare it field by
  // field with the oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : watch_replies
    bpra_pkg::rsp_t want;
    bpra_pkg::op_t  want_op;
    if (!rst && done) begin
      if (expected_replies.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected reply: status %0d index %0d", $time,
                 rsp.status, rsp.found_index);
      end else begin
        want    = expected_replies.pop_front();
        want_op = expected_ops.pop_front();
        if (rsp.status !== want.status) begin
          mismatches++;
          $display("%0t: status mismatch: expected %s, actual %0d", $time,
                   want.status.name(), rsp.status);
        end
        if (rsp.found_index !== want.found_index) begin
          mismatches++;
          $display("%0t: found_index mismatch: expected %0d, actual %0d", $time,
                   want.found_index, rsp.found_index);
        end
        case (want.status)
          bpra_pkg::ST_DONE:    if (want_op == bpra_pkg::OP_ALLOC) n_placed++;
                                else n_released++;
          bpra_pkg::ST_NOFIT:   n_nofit++;
          bpra_pkg::ST_BADFREE: n_badfree++;
          default:              n_empty++;
        endcase
      end
    end
  end

  // Count cycles with neither a request nor a reply transfer.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(negedge clk);
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic void push_alloc(int len);
    backlog_t b;
    b = '0;
    b.item.op          = bpra_pkg::OP_ALLOC;
    b.item.run_length  = bpra_pkg::CNT_W'(len);
    b.item.start_index = bpra_pkg::PAGE_W'($urandom);   // don't care on allocate
    request_backlog.push_back(b);
  endfunction

  function automatic void push_free(int first, int len);
    backlog_t b;
    b = '0;
    b.item.op          = bpra_pkg::OP_FREE;
    b.item.run_length  = bpra_pkg::CNT_W'(len);
    b.item.start_index = bpra_pkg::PAGE_W'(first);
    request_backlog.push_back(b);
  endfunction

  function automatic void push_pool(int pages);
    backlog_t b;
    b = '0;
    b.is_cfg     = 1'b1;
    b.pool_value = bpra_pkg::CNT_W'(pages);
    request_backlog.push_back(b);
  endfunction

  // Sampled on the falling edge so it never races the clocked blocks.
  task automatic wait_idle();
    while (request_backlog.size() != 0 || expected_replies.size() != 0 ||
           busy || start || cfg_we)
      @(negedge clk);
  endtask

  function automatic int pick_alloc_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 8);
    if (r < 85) return $urandom_range(9, 64);
    if (r < 97) return $urandom_range(65, 256);
    return $urandom_range(257, bpra_pkg::MAX_PAGES);
  endfunction

  function automatic int pick_pool();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return bpra_pkg::MAX_PAGES;
    if (r < 65) return $urandom_range(512, bpra_pkg::MAX_PAGES - 1);
    if (r < 75) return $urandom_range(65, 511);
    if (r < 88) return $urandom_range(1, 64);
    if (r < 93) return 0;
    // acts as full size
    return $urandom_range(bpra_pkg::MAX_PAGES + 1, (1 << bpra_pkg::CNT_W) - 1);
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int span_lo[$];
    int span_len[$];
    int issued;
    int phase_len;
    int k, s, l, a, b, r;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero lengths, single page and whole-pool runs, frees past
    // the pool end, frees over free pages, all-ones start index, then the
    // pool shrunk under used pages, an empty pool and an oversized value.
    push_alloc(0);
    push_free(bpra_pkg::MAX_PAGES - 1, 0);
    push_alloc(1);
    push_alloc(bpra_pkg::MAX_PAGES);
    push_free(0, 1);
    push_alloc(bpra_pkg::MAX_PAGES);
    push_free(bpra_pkg::MAX_PAGES - 1, 2);
    push_free(0, bpra_pkg::MAX_PAGES);
    push_free(5, 3);
    push_alloc(3);
    push_alloc(5);
    push_free(0, 3);
    push_alloc(2);
    push_free(bpra_pkg::MAX_PAGES - 1, 1);
    push_free(512, bpra_pkg::MAX_PAGES);
    push_alloc(200);
    push_pool(50);
    push_alloc(60);
    push_free(100, 4);
    push_alloc(1);
    push_pool(0);
    push_alloc(1);
    push_free(0, 1);
    push_pool((1 << bpra_pkg::CNT_W) - 1);
    push_alloc(600);
    push_pool(bpra_pkg::MAX_PAGES);
    wait_idle();

    // Random phases. Each phase starts from a drained unit, reads the
    // predicted map for runs that are in use, and frees pieces of those,
    // mixed with allocations and a share of malformed requests.
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 20) push_pool(pick_pool());
      span_lo.delete();
      span_len.delete();
      for (int i = 0; i < bpra_pkg::MAX_PAGES; i++) begin
        if (page_map[i]) begin
          if (i == 0 || !page_map[i-1]) begin
            span_lo.push_back(i);
            span_len.push_back(1);
          end else begin
            span_len[span_len.size()-1]++;
          end
        end
      end
      phase_len = $urandom_range(20, 60);
      for (int n = 0; n < phase_len; n++) begin
        r = $urandom_range(0, 99);
        if (r < 35 && span_lo.size() != 0) begin
          k = $urandom_range(0, span_lo.size() - 1);
          s = span_lo[k];
          l = span_len[k];
          span_lo.delete(k);
          span_len.delete(k);
          if ($urandom_range(0, 99) < 65) begin
            push_free(s, l);
          end else begin
            // free a piece; any leftover on either side stays in use
            a = $urandom_range(0, l - 1);
            b = $urandom_range(1, l - a);
            push_free(s + a, b);
            if (a > 0) begin
              span_lo.push_back(s);
              span_len.push_back(a);
            end
            if (l - a - b > 0) begin
              span_lo.push_back(s + a + b);
              span_len.push_back(l - a - b);
            end
          end
        end else if (r < 82) begin
          push_alloc(pick_alloc_len());
        end else begin
          // malformed or off-target requests
          case ($urandom_range(0, 4))
            0: push_alloc(0);
            1: push_free($urandom_range(0, bpra_pkg::MAX_PAGES - 1), 0);
            2: push_free($urandom_range(0, bpra_pkg::MAX_PAGES - 1),
                         $urandom_range(1, 16));
            3: push_free($urandom_range(0, bpra_pkg::MAX_PAGES - 1),
                         $urandom_range(1, bpra_pkg::MAX_PAGES));
            default: push_alloc($urandom_range(bpra_pkg::MAX_PAGES - 16,
                                               bpra_pkg::MAX_PAGES));
          endcase
        end
        issued++;
      end
      wait_idle();
    end

    // settle: no reply may show up once nothing is expected
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Covered %0d pool writes and %0d replies:", n_pool_writes,
             n_placed + n_nofit + n_released + n_badfree + n_empty);
    $display("  %0d runs placed, %0d released, %0d no fit, %0d bad free, %0d empty free",
             n_placed, n_released, n_nofit, n_badfree, n_empty);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/bpra_pkg.sv
rtl/bpra_map.sv
rtl/bpra_ctrl.sv
rtl/bitmap_page_run_allocator_unit.sv
sim/tb_bitmap_page_run_allocator_unit.sv
